>>> rtl/core/quadtree_leaf_position_tracker_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef QUADTREE_LEAF_POSITION_TRACKER_DEFINES_SVH
`define QUADTREE_LEAF_POSITION_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QLPT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QLPT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qlpt_pkg.sv
package qlpt_pkg;

    localparam int LEVEL_W     = 2;
    localparam int TSL_W       = 4;
    localparam int COUNT_W     = 10;
    localparam int TILE_W      = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILES_ACROSS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILES_DOWN    = 2'd2;

    localparam logic [TSL_W-1:0]   TOP_SIZE_LOG2_RESET = 4'd5;
    localparam logic [COUNT_W-1:0] TILE_COUNT_RESET    = 10'd1;
    localparam logic [COUNT_W-1:0] TILE_COUNT_MAX      = 10'd512;

    typedef enum logic [1:0] {
        STATUS_PLACED     = 2'd0,
        STATUS_MISALIGNED = 2'd1,
        STATUS_COMPLETE   = 2'd2
    } status_t;

    typedef struct packed {
        logic               too_deep;
        logic [LEVEL_W-1:0] level;
    } leaf_req_t;

    typedef struct packed {
        logic [TSL_W-1:0]   top_size_log2;
        logic [COUNT_W-1:0] tiles_across;
        logic [COUNT_W-1:0] tiles_down;
    } tracker_cfg_t;

endpackage

>>> rtl/core/quadtree_leaf_position_tracker.sv
// Quadtree leaf position tracker.
// Each request on the s_ channel carries the depth of the next leaf block in
// stream order, and the m_ channel returns exactly one result per request:
// the pixel offset of the leaf's top-left corner, a status code and a flag
// that marks the leaf that completed the last tile of the image.
// A request is taken into a two-entry queue, and its result is then written
// to the output register. One request per cycle is sustained while the
// receiver keeps m_ready high; the back end updates the fill index and tile
// position for each request that it pops, and that update sets the rate.
// When the receiver holds m_ready low, the result waits in the output
// register, the queue takes up to two more requests, and then s_ready drops.
// Registers are written on the cfg_ channel, which is always ready, and
// should be written only while no request is in flight.
// Reset clears the fill index, the tile position, the completion flag, the
// queue and the output valid flag, and restores the registers to a top size
// of 32 pixels and a one by one tile image.
module quadtree_leaf_position_tracker
    import qlpt_pkg::*;
#(
    parameter int LEVELS     = 4,
    parameter int COORD_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [LEVEL_W-1:0]     s_block_level,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_BITS-1:0]  m_x_offset,
    output logic [COORD_BITS-1:0]  m_y_offset,
    output logic [1:0]             m_status,
    output logic                   m_image_done
);

    tracker_cfg_t cfg_reg, cfg_next;
    logic         push, pop, queue_full, head_valid;
    leaf_req_t    push_req, head_req;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TOP_SIZE_LOG2: cfg_next.top_size_log2 = cfg_data[TSL_W-1:0];
                CFG_TILES_ACROSS:  cfg_next.tiles_across  = cfg_data;
                CFG_TILES_DOWN:    cfg_next.tiles_down    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_size_log2 <= TOP_SIZE_LOG2_RESET;
            cfg_reg.tiles_across  <= TILE_COUNT_RESET;
            cfg_reg.tiles_down    <= TILE_COUNT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qlpt_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_block_level (s_block_level),
        .push          (push),
        .push_req      (push_req),
        .queue_full    (queue_full)
    );

    qlpt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    qlpt_back #(
        .LEVELS     (LEVELS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_req     (head_req),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_x_offset   (m_x_offset),
        .m_y_offset   (m_y_offset),
        .m_status     (m_status),
        .m_image_done (m_image_done)
    );

endmodule

>>> rtl/core/qlpt_front.sv
module qlpt_front
    import qlpt_pkg::*;
#(
    parameter int LEVELS = 4
) (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LEVEL_W-1:0] s_block_level,
    output logic               push,
    output leaf_req_t          push_req,
    input  logic               queue_full
);

    localparam logic [TSL_W-1:0] LEVEL_LIMIT = TSL_W'(LEVELS);

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        push_req.level    = s_block_level;
        push_req.too_deep = (TSL_W'(s_block_level) >= LEVEL_LIMIT);
    end

endmodule

>>> rtl/core/qlpt_queue.sv
module qlpt_queue
    import qlpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  leaf_req_t push_req,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output leaf_req_t head_req
);

    localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    leaf_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_req   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

>>> rtl/core/qlpt_back.sv
module qlpt_back
    import qlpt_pkg::*;
#(
    parameter int LEVELS     = 4,
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tracker_cfg_t          cfg,
    input  logic                  head_valid,
    input  leaf_req_t             head_req,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_x_offset,
    output logic [COORD_BITS-1:0] m_y_offset,
    output logic [1:0]            m_status,
    output logic                  m_image_done
);

    localparam int IDX_BITS = 2 * (LEVELS - 1);
    localparam int SUB_BITS = LEVELS - 1;
    localparam logic [TSL_W-1:0] FINE_SHIFT = TSL_W'(LEVELS - 1);

    logic [IDX_BITS-1:0]   fill_reg, fill_next;
    logic [TILE_W-1:0]     col_reg, col_next;
    logic [TILE_W-1:0]     row_reg, row_next;
    logic                  complete_reg, complete_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    status_t               status_reg, status_next;
    logic                  done_reg, done_next;

    logic [IDX_BITS-1:0]   span_mask;
    logic [IDX_BITS:0]     fill_sum;
    logic [SUB_BITS-1:0]   sub_x, sub_y;
    logic [TSL_W-1:0]      unit_log2;
    logic [COUNT_W-1:0]    across_eff, down_eff;
    logic                  misaligned, tile_full, last_col, last_row;
    logic [COORD_BITS-1:0] x_pos, y_pos;

    assign pop          = head_valid && (!out_valid_reg || m_ready);
    assign m_valid      = out_valid_reg;
    assign m_x_offset   = x_reg;
    assign m_y_offset   = y_reg;
    assign m_status     = status_reg;
    assign m_image_done = done_reg;

    always_comb begin
        for (int k = 0; k < SUB_BITS; k++) begin
            span_mask[2*k +: 2] = ((TSL_W'(k) + TSL_W'(head_req.level)) < FINE_SHIFT) ?
                                  2'b11 : 2'b00;
            sub_x[k] = fill_reg[2*k];
            sub_y[k] = fill_reg[2*k + 1];
        end
    end

    always_comb begin
        misaligned = head_req.too_deep || ((fill_reg & span_mask) != '0);
        fill_sum   = {1'b0, fill_reg} + {1'b0, span_mask} + (IDX_BITS + 1)'(1);
        tile_full  = fill_sum[IDX_BITS];

        unit_log2 = (cfg.top_size_log2 >= FINE_SHIFT) ?
                    cfg.top_size_log2 - FINE_SHIFT : '0;

        if (cfg.tiles_across == '0) begin
            across_eff = TILE_COUNT_RESET;
        end else if (cfg.tiles_across > TILE_COUNT_MAX) begin
            across_eff = TILE_COUNT_MAX;
        end else begin
            across_eff = cfg.tiles_across;
        end
        if (cfg.tiles_down == '0) begin
            down_eff = TILE_COUNT_RESET;
        end else if (cfg.tiles_down > TILE_COUNT_MAX) begin
            down_eff = TILE_COUNT_MAX;
        end else begin
            down_eff = cfg.tiles_down;
        end
        last_col = (({1'b0, col_reg} + COUNT_W'(1)) >= across_eff);
        last_row = (({1'b0, row_reg} + COUNT_W'(1)) >= down_eff);

        x_pos = (COORD_BITS'(col_reg) << cfg.top_size_log2)
              + (COORD_BITS'(sub_x) << unit_log2);
        y_pos = (COORD_BITS'(row_reg) << cfg.top_size_log2)
              + (COORD_BITS'(sub_y) << unit_log2);
    end

    always_comb begin
        fill_next      = fill_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        complete_next  = complete_reg;
        out_valid_next = out_valid_reg && !m_ready;
        x_next         = x_reg;
        y_next         = y_reg;
        status_next    = status_reg;
        done_next      = done_reg;

        if (pop) begin
            out_valid_next = 1'b1;
            x_next         = '0;
            y_next         = '0;
            done_next      = 1'b0;
            if (complete_reg) begin
                status_next = STATUS_COMPLETE;
            end else if (misaligned) begin
                status_next = STATUS_MISALIGNED;
            end else begin
                status_next = STATUS_PLACED;
                x_next      = x_pos;
                y_next      = y_pos;
                fill_next   = fill_sum[IDX_BITS-1:0];
                if (tile_full) begin
                    if (last_col) begin
                        col_next = '0;
                        if (last_row) begin
                            row_next      = '0;
                            complete_next = 1'b1;
                            done_next     = 1'b1;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            complete_reg  <= complete_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        status_reg <= status_next;
        done_reg   <= done_next;
    end

endmodule

>>> rtl/core/qlpt_checker.sv
`include "quadtree_leaf_position_tracker_defines.svh"

module qlpt_checker
    import qlpt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_x_offset,
    input logic [COORD_BITS-1:0] m_y_offset,
    input logic [1:0]            m_status,
    input logic                  m_image_done
);

    // A stalled result keeps its fields until it is taken.
    `QLPT_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_x_offset) && $stable(m_y_offset) && $stable(m_status) && $stable(m_image_done), "stalled result changed")

    // A rejected leaf reports no position and never completes the image.
    `QLPT_ASSERT_NOW(a_error_zero, aclk, aresetn, m_valid && (m_status != STATUS_PLACED), (m_x_offset == '0) && (m_y_offset == '0) && !m_image_done, "error result carries data")

    // Only a placed leaf can finish the image.
    `QLPT_ASSERT_NOW(a_done_placed, aclk, aresetn, m_valid && m_image_done, m_status == STATUS_PLACED, "image done on a rejected leaf")

    // Right after the final leaf is taken, the next result can only be a completion error.
    `QLPT_ASSERT_NEXT(a_done_then_complete, aclk, aresetn, m_valid && m_ready && m_image_done, !m_valid || (m_status == STATUS_COMPLETE), "leaf accepted after the image completed")

endmodule

bind quadtree_leaf_position_tracker qlpt_checker #(
    .COORD_BITS (COORD_BITS)
) u_qlpt_checker (.*);
